[rtl/core/seqrob_pkg.sv]
// ----------------------------------------------------------------------------
// seqrob_pkg
// Shared types and constants for the sequence reorder buffer.
// ----------------------------------------------------------------------------
package seqrob_pkg;

    localparam int SEQROB_DEPTH = 16;   // default window depth
    localparam int MAX_RESULTS  = 16;   // result words per input word, at most
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_EMIT    = 2'd0;
    localparam logic [1:0] STAT_FLUSHED = 2'd1;
    localparam logic [1:0] STAT_DROPPED = 2'd2;
    localparam logic [1:0] STAT_EMPTY   = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [31:0] seq_number;
        logic [63:0] payload;
    } seqrob_in_t;

    typedef struct packed {
        logic [31:0] out_seq;
        logic [63:0] out_payload;
        logic [1:0]  status;
        logic        last;
    } seqrob_out_t;

endpackage

[rtl/core/sequence_reorder_buffer.sv]
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Each emitted word passes a scan state and then a load state (payload RAM
// read) before the output register; dropped inserts and empty flushes answer
// in the cycle after acceptance. An insert holds the input until it has
// drained the words it frees, a flush until it has drained its words,
// stepping over the empty window slots between them. Output stalls hold the
// load state. The output rate is set by the single-port payload RAM.
// Reset (aresetn, synchronous): window empty, next expected = 0; no clearing
// pass, the slot valid bits are flip-flops cleared at once.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer #(
    parameter int DEPTH = seqrob_pkg::SEQROB_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  seqrob_pkg::seqrob_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output seqrob_pkg::seqrob_out_t m_data
);
    import seqrob_pkg::*;

    localparam int SLOT_W   = $clog2(DEPTH);
    localparam int SUM_W    = SLOT_W + 2;
    // 2^32 mod DEPTH: slot shift when a window position wraps the seq space
    localparam int WRAP_REM = int'((64'd1 << 32) % DEPTH);
    localparam int WRAP_ADJ = DEPTH - WRAP_REM;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    // next slot along the sequence space, with the wrap at 2^32 folded in
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [31:0]       seq,
                                                   input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] r;
        if (seq == 32'hFFFF_FFFF) begin
            r = '0;
        end else if (slot == SLOT_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = slot + SLOT_W'(1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic               flush_mode_reg, flush_mode_next;
    logic [DEPTH-1:0]   slot_valid_reg, slot_valid_next;
    logic [31:0]        ne_reg, ne_next;            // next expected sequence
    logic [SLOT_W-1:0]  ne_slot_reg, ne_slot_next;  // its slot, kept alongside
    logic [31:0]        scan_seq_reg, scan_seq_next;    // flush walk position
    logic [SLOT_W-1:0]  scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;          // words out for this input
    logic               m_valid_reg, m_valid_next;
    seqrob_out_t        m_data_reg, m_data_next;

    // payload RAM, one write or one read a cycle, registered read data
    logic [63:0]        pay_mem [DEPTH];
    logic [63:0]        rd_data_reg;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_slot;
    logic               rd_en;

    // ------------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------------
    logic               s_acc;
    logic               out_free;
    logic               out_load;
    logic [31:0]        seq_offset;
    logic               in_win;
    logic               seq_wrapped;
    logic [SUM_W-1:0]   sum0, sum1, sum2;
    logic [SLOT_W-1:0]  ins_slot;
    logic [SLOT_W-1:0]  cur_slot;
    logic [31:0]        cur_seq;
    logic [SLOT_W-1:0]  nxt_slot;
    logic [DEPTH-1:0]   valid_less_cur;
    logic               any_valid;
    logic               cap_hit;
    logic               load_last;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_valid && s_ready;

    // window check: distance from next expected, modulo 2^32
    assign seq_offset  = s_data.seq_number - ne_reg;
    assign in_win      = seq_offset < 32'(DEPTH);
    assign seq_wrapped = s_data.seq_number < ne_reg;

    // slot = seq mod DEPTH, built from the tracked slot of next expected
    assign sum0 = SUM_W'(ne_slot_reg) + SUM_W'(seq_offset[SLOT_W-1:0])
                + (seq_wrapped ? SUM_W'(WRAP_ADJ) : SUM_W'(0));
    assign sum1 = (sum0 >= SUM_W'(DEPTH)) ? sum0 - SUM_W'(DEPTH) : sum0;
    assign sum2 = (sum1 >= SUM_W'(DEPTH)) ? sum1 - SUM_W'(DEPTH) : sum1;
    assign ins_slot = sum2[SLOT_W-1:0];

    // slot under the drain or flush walk
    assign cur_slot = flush_mode_reg ? scan_slot_reg : ne_slot_reg;
    assign cur_seq  = flush_mode_reg ? scan_seq_reg  : ne_reg;
    assign nxt_slot = slot_inc(cur_seq, cur_slot);

    always_comb begin
        valid_less_cur           = slot_valid_reg;
        valid_less_cur[cur_slot] = 1'b0;
    end

    assign any_valid = |slot_valid_reg;
    assign cap_hit   = cnt_reg == CNT_W'(MAX_RESULTS - 1);

    // last word: drain stops at a gap, a flush when nothing else is held; both stop at the result cap
    always_comb begin
        if (flush_mode_reg) begin
            load_last = cap_hit || !(|valid_less_cur);
        end else begin
            load_last = cap_hit || !valid_less_cur[nxt_slot];
        end
    end

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        flush_mode_next = flush_mode_reg;
        slot_valid_next = slot_valid_reg;
        ne_next         = ne_reg;
        ne_slot_next    = ne_slot_reg;
        scan_seq_next   = scan_seq_reg;
        scan_slot_next  = scan_slot_reg;
        cnt_next        = cnt_reg;
        wr_en           = 1'b0;
        wr_slot         = ins_slot;
        rd_en           = 1'b0;
        out_load        = 1'b0;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cnt_next = '0;
                    if (s_data.operation == OP_FLUSH) begin
                        if (any_valid) begin
                            flush_mode_next = 1'b1;
                            scan_seq_next   = ne_reg;
                            scan_slot_next  = ne_slot_reg;
                            state_next      = ST_SCAN;
                        end else begin
                            // nothing held: one status word, back to reset state
                            out_load    = 1'b1;
                            m_data_next = '{out_seq: '0, out_payload: '0,
                                            status: STAT_EMPTY, last: 1'b1};
                            ne_next      = '0;
                            ne_slot_next = '0;
                        end
                    end else if (in_win) begin
                        wr_en                     = 1'b1;
                        slot_valid_next[ins_slot] = 1'b1;
                        flush_mode_next           = 1'b0;
                        state_next                = ST_SCAN;
                    end else begin
                        out_load    = 1'b1;
                        m_data_next = '{out_seq: s_data.seq_number,
                                        out_payload: s_data.payload,
                                        status: STAT_DROPPED, last: 1'b1};
                    end
                end
            end

            ST_SCAN: begin
                if (slot_valid_reg[cur_slot]) begin
                    rd_en      = 1'b1;
                    state_next = ST_LOAD;
                end else if (flush_mode_reg) begin
                    // empty slot in the flush walk, step over it
                    scan_seq_next  = scan_seq_reg + 32'd1;
                    scan_slot_next = nxt_slot;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_LOAD: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    m_data_next = '{out_seq: cur_seq, out_payload: rd_data_reg,
                                    status: flush_mode_reg ? STAT_FLUSHED : STAT_EMIT,
                                    last: load_last};
                    slot_valid_next[cur_slot] = 1'b0;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (flush_mode_reg) begin
                        scan_seq_next  = scan_seq_reg + 32'd1;
                        scan_slot_next = nxt_slot;
                    end else begin
                        ne_next      = ne_reg + 32'd1;
                        ne_slot_next = nxt_slot;
                    end
                    if (load_last) begin
                        state_next = ST_IDLE;
                        if (flush_mode_reg) begin
                            // flush ends in the reset state, leftovers discarded
                            slot_valid_next = '0;
                            ne_next         = '0;
                            ne_slot_next    = '0;
                        end
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            flush_mode_reg <= 1'b0;
            slot_valid_reg <= '0;
            ne_reg         <= '0;
            ne_slot_reg    <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            flush_mode_reg <= flush_mode_next;
            slot_valid_reg <= slot_valid_next;
            ne_reg         <= ne_next;
            ne_slot_reg    <= ne_slot_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_seq_reg  <= scan_seq_next;
        scan_slot_reg <= scan_slot_next;
        m_data_reg    <= m_data_next;
    end

    // payload RAM
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pay_mem[wr_slot] <= s_data.payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= pay_mem[cur_slot];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // the slot being read out must still hold a word
    a_load_slot_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> slot_valid_reg[cur_slot])
        else $error("reading out a slot that holds no word");

    // an out-of-window insert answers with a single dropped word next cycle
    a_drop_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_data.operation == OP_INSERT && !in_win |=>
            m_valid_reg && m_data_reg.status == STAT_DROPPED && m_data_reg.last)
        else $error("dropped insert not answered");

    // a finished flush leaves the window empty at sequence zero
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && flush_mode_reg && load_last && state_reg == ST_LOAD |=>
            slot_valid_reg == '0 && ne_reg == '0 && state_reg == ST_IDLE)
        else $error("flush did not return to the reset state");

    // never more result words than the limit for one input word
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count over limit");

endmodule

[bench/sequence_reorder_buffer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_tb
// Drives tagged words into the reorder buffer and checks that they leave in
// sequence order. A behavioural window model predicts every result word at
// input acceptance. A monitor compares the words that come out against those
// predictions, in order. Traffic is a directed opening followed by three
// random phases with different back-pressure.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_tb;
    import seqrob_pkg::*;

    localparam int DEPTH         = SEQROB_DEPTH;
    localparam int CYCLE_LIMIT   = 300000;  // well above the slowest legal run
    localparam int SETTLE_CYCLES = 64;      // covers a full flush scan and drain

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    seqrob_in_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    seqrob_out_t m_data;

    // Words waiting for the driver, and result words still owed by the block
    seqrob_in_t  pending_words[$];
    seqrob_out_t expected_words[$];

    int          words_queued = 0;   // written by the stimulus process only
    int          words_sent   = 0;   // written by the monitor only
    int          cycle_count  = 0;
    int          mismatches   = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        in_taken = 1'b0;    // input word accepted at the last rising edge
    logic [31:0] gen_base = '0;      // stimulus view of the next expected sequence

    // Window model: one valid bit and payload per slot, plus the next number
    logic        window_valid[DEPTH];
    logic [63:0] window_payload[DEPTH];
    logic [31:0] model_next_seq;

    sequence_reorder_buffer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic seqrob_out_t make_word(input logic [31:0] seq,
                                              input logic [63:0] pay,
                                              input logic [1:0]  stat);
        seqrob_out_t w;
        w.out_seq     = seq;
        w.out_payload = pay;
        w.status      = stat;
        w.last        = 1'b0;
        return w;
    endfunction

    function automatic int slot_index(input logic [31:0] seq);
        return int'(seq % 32'(DEPTH));
    endfunction

    // Work out the result words caused by one accepted input word
    task automatic reorder_step(input seqrob_in_t w);
        logic [31:0] seq_offset;
        logic [31:0] sq;
        seqrob_out_t r;
        int          n;
        n          = 0;
        seq_offset = w.seq_number - model_next_seq;
        if (w.operation == OP_INSERT) begin
            if (seq_offset >= 32'(DEPTH)) begin
                // behind the window or too far ahead: bounced, state untouched
                r      = make_word(w.seq_number, w.payload, STAT_DROPPED);
                r.last = 1'b1;
                expected_words.push_back(r);
            end else begin
                window_valid[slot_index(w.seq_number)]   = 1'b1;
                window_payload[slot_index(w.seq_number)] = w.payload;
                // drain the consecutive run, capped per input word
                while (n < MAX_RESULTS && window_valid[slot_index(model_next_seq)]) begin
                    expected_words.push_back(make_word(model_next_seq,
                        window_payload[slot_index(model_next_seq)], STAT_EMIT));
                    window_valid[slot_index(model_next_seq)] = 1'b0;
                    model_next_seq = model_next_seq + 32'd1;
                    n++;
                end
                if (n > 0)
                    expected_words[expected_words.size() - 1].last = 1'b1;
            end
        end else begin
            // flush in window order, i.e. ascending sequence from next expected
            for (int off = 0; off < DEPTH; off++) begin
                sq = model_next_seq + 32'(off);
                if (window_valid[slot_index(sq)] && n < MAX_RESULTS) begin
                    expected_words.push_back(make_word(sq,
                        window_payload[slot_index(sq)], STAT_FLUSHED));
                    window_valid[slot_index(sq)] = 1'b0;
                    n++;
                end
            end
            for (int k = 0; k < DEPTH; k++)
                window_valid[k] = 1'b0;
            model_next_seq = '0;
            if (n == 0) begin
                r      = make_word('0, '0, STAT_EMPTY);
                r.last = 1'b1;
                expected_words.push_back(r);
            end else begin
                expected_words[expected_words.size() - 1].last = 1'b1;
            end
        end
    endtask

    task automatic flag_word(input bit have_exp, input seqrob_out_t want,
                             input seqrob_out_t got);
        mismatches++;
        if (mismatches <= 10) begin
            if (!have_exp)
                $display("unexpected word: seq %h payload %h status %0d last %0d",
                         got.out_seq, got.out_payload, got.status, got.last);
            else
                $display({"mismatch: exp seq %h payload %h status %0d last %0d, ",
                          "got seq %h payload %h status %0d last %0d"},
                         want.out_seq, want.out_payload, want.status, want.last,
                         got.out_seq, got.out_payload, got.status, got.last);
        end
    endtask

    function automatic logic [63:0] rand_handle();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_insert(input logic [31:0] seq, input logic [63:0] pay);
        seqrob_in_t w;
        w.operation  = OP_INSERT;
        w.seq_number = seq;
        w.payload    = pay;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // seq and payload are don't-care on a flush, so they carry noise
    task automatic queue_flush();
        seqrob_in_t w;
        w.operation  = OP_FLUSH;
        w.seq_number = $urandom;
        w.payload    = rand_handle();
        pending_words.push_back(w);
        words_queued++;
        gen_base = '0;
    endtask

    // Mostly clean runs of consecutive numbers in shuffled order; the rest is
    // abandoned runs closed by a flush, stray numbers, bare flushes and
    // early arrivals that sit in the window.
    task automatic random_traffic(input int count);
        int          made;
        int          len;
        int          pick;
        int          tmp;
        int          j;
        int          order[DEPTH];
        logic [31:0] seq;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = ($urandom_range(7) == 0) ? DEPTH : $urandom_range(1, 6);
                for (j = 0; j < len; j++)
                    order[j] = j;
                for (j = len - 1; j > 0; j--) begin
                    tmp        = $urandom_range(j);
                    seq        = order[j];
                    order[j]   = order[tmp];
                    order[tmp] = seq;
                end
                for (j = 0; j < len; j++) begin
                    queue_insert(gen_base + 32'(order[j]), rand_handle());
                    // occasional repeat: overwrite if still held, else stale
                    if ($urandom_range(11) == 0) begin
                        queue_insert(gen_base + 32'(order[j]), rand_handle());
                        made++;
                    end
                end
                made     += len;
                gen_base += 32'(len);
            end else if (pick < 80) begin
                len = $urandom_range(2, DEPTH);
                for (j = len - 1; j >= 0; j--)
                    if ($urandom_range(9) < 6) begin
                        queue_insert(gen_base + 32'(j), rand_handle());
                        made++;
                    end
                queue_flush();
                made++;
            end else if (pick < 88) begin
                case ($urandom_range(2))
                    0:       seq = $urandom;
                    1:       seq = gen_base - 32'd1 - 32'($urandom_range(40));
                    default: seq = gen_base + 32'(DEPTH) + 32'($urandom_range(200));
                endcase
                queue_insert(seq, rand_handle());
                made++;
            end else if (pick < 94) begin
                queue_flush();
                made++;
            end else begin
                queue_insert(gen_base + 32'($urandom_range(1, DEPTH - 1)), rand_handle());
                made++;
            end
        end
    endtask

    // Hold off until every queued word is in and every result word is out
    task automatic wait_drained();
        while (words_sent != words_queued || expected_words.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: inputs move on the falling edge only
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            // a presented word is held until the rising edge that takes it
            if (!s_valid || in_taken) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance
    always @(posedge aclk) begin
        seqrob_out_t want;
        cycle_count++;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            // predicting first is safe: new words go to the back of the queue
            if (s_valid && s_ready) begin
                reorder_step(s_data);
                words_sent++;
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    flag_word(1'b0, m_data, m_data);
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.out_seq !== want.out_seq ||
                        m_data.out_payload !== want.out_payload ||
                        m_data.status !== want.status ||
                        m_data.last !== want.last)
                        flag_word(1'b1, want, m_data);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(negedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        for (int k = 0; k < DEPTH; k++)
            window_valid[k] = 1'b0;
        model_next_seq = '0;
        send_idle_pct  = 23;
        recv_idle_pct  = 58;

        // Directed opening
        queue_flush();                                   // flush with nothing held
        queue_insert(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // one behind, wraps
        queue_insert(32'd16, rand_handle());             // one past the far edge
        queue_insert(32'd15, 64'h0);                     // far edge, held
        queue_insert(32'd15, rand_handle());             // same slot, overwritten
        for (int k = 14; k >= 1; k--)
            queue_insert(32'(k), rand_handle());         // fill the window backwards
        queue_insert(32'd0, 64'hFFFF_FFFF_FFFF_FFFF);    // completes a full 16-word run
        queue_insert(32'd17, rand_handle());
        queue_insert(32'd19, rand_handle());
        queue_flush();                                   // leftovers 17 and 19

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        random_traffic(125);
        wait_drained();

        send_idle_pct = 58;
        recv_idle_pct = 23;
        random_traffic(125);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(120);
        wait_drained();

        // let any stray word surface before the verdict
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (expected_words.size() != 0) begin
            mismatches++;
            $display("%0d result words never arrived", expected_words.size());
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/seqrob_pkg.sv
rtl/core/sequence_reorder_buffer.sv
bench/sequence_reorder_buffer_tb.sv
